// ----- src/isotp_rr_pkg.sv -----
// Shared constants and types for the ISO-TP receive reassembler.
package isotp_rr_pkg;

    // Message buffer size in bytes; the store keeps eight bytes of slack
    localparam int BUFFER_BYTES = 256;
    localparam int MAX_RESULTS  = 32;
    localparam int STORE_WORDS  = (BUFFER_BYTES + 15) / 8;
    localparam int STORE_ADDR_W = $clog2(STORE_WORDS);
    localparam int LIMIT_CAP    = (BUFFER_BYTES < 8 * MAX_RESULTS) ?
                                  BUFFER_BYTES : 8 * MAX_RESULTS;

    // Field widths
    localparam int BYTES_W = 64;
    localparam int COUNT_W = 4;
    localparam int LEN_W   = 9;
    localparam int SID_W   = 8;
    localparam int TIMER_W = 16;
    localparam int SEQ_W   = 4;

    // Configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam logic [2:0] REG_MAX_LEN   = 3'd0;
    localparam logic [2:0] REG_OBD_FIRST = 3'd1;
    localparam logic [2:0] REG_UDS_FIRST = 3'd2;
    localparam logic [2:0] REG_TIMEOUT   = 3'd3;
    localparam logic [2:0] REG_SEP_TIME  = 3'd4;

    // Frame types (upper nibble of byte 0)
    localparam logic [3:0] TYPE_SINGLE = 4'h0;
    localparam logic [3:0] TYPE_FIRST  = 4'h1;
    localparam logic [3:0] TYPE_CONSEC = 4'h2;
    localparam logic [3:0] TYPE_FLOW   = 4'h3;

    // Flow-control codes
    localparam logic [3:0] FC_CONT  = 4'h0;
    localparam logic [3:0] FC_WAIT  = 4'h1;
    localparam logic [3:0] FC_ABORT = 4'h2;
    localparam logic [3:0] FC_BASE  = 4'h3;

    // Result kinds
    localparam logic KIND_FLOW = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef struct packed {
        logic               result_kind;
        logic [BYTES_W-1:0] result_bytes;
        logic [COUNT_W-1:0] byte_count;
        logic               destination;
        logic [LEN_W-1:0]   message_length;
        logic               last_word;
    } result_t;

endpackage

// ----- src/isotp_rr_frame_if.sv -----
// Input channel: received CAN frames and timer ticks.
interface isotp_rr_frame_if import isotp_rr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [BYTES_W-1:0] frame_bytes;

    modport source (output valid, output mode, output frame_bytes, input ready);
    modport sink   (input valid, input mode, input frame_bytes, output ready);
endinterface

// ----- src/isotp_rr_result_if.sv -----
// Output channel: flow-control replies and message data words.
interface isotp_rr_result_if import isotp_rr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [BYTES_W-1:0] result_bytes;
    logic [COUNT_W-1:0] byte_count;
    logic               destination;
    logic [LEN_W-1:0]   message_length;
    logic               last_word;

    modport source (output valid, output result_kind, output result_bytes,
                    output byte_count, output destination, output message_length,
                    output last_word, input ready);
    modport sink   (input valid, input result_kind, input result_bytes,
                    input byte_count, input destination, input message_length,
                    input last_word, output ready);
endinterface

// ----- src/isotp_receive_reassembler_unit.sv -----
// Top level of the ISO-TP receive reassembler: decode, message store, delivery.
//
//  Channel   Direction  Beat contents
//  frame     in         mode, frame_bytes (CAN frame or timer tick)
//  result    out        result_kind, result_bytes, byte_count, destination,
//                       message_length, last_word
//  APB       in/out     five configuration registers at byte address 4*i
//
// An input beat is taken only in idle; a flow reply is sent from a pending state, with a wait reply
// ahead of it for a first frame that arrives mid-message. A consecutive frame writes its seven bytes
// in two parts, head then held tail, through the single store write port. Delivery reads one store
// word at a time (read, then register into the output), waiting while the result channel stalls.
// Reset clears control state only; the message store needs no clearing pass.
// A stalled result register holds the sequencer; an input beat waits until idle.
module isotp_receive_reassembler_unit import isotp_rr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    isotp_rr_frame_if.sink        frame,
    isotp_rr_result_if.source     result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WAIT = 3'd1;
    localparam logic [2:0] S_PEND = 3'd2;
    localparam logic [2:0] S_CF2  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_DW   = 3'd5;

    // Configuration registers
    logic [LEN_W-1:0]   max_len_reg;
    logic [SID_W-1:0]   obd_first_reg;
    logic [SID_W-1:0]   uds_first_reg;
    logic [TIMER_W-1:0] timeout_reg;
    logic [7:0]         sep_time_reg;

    // Reassembly state
    logic [2:0]              state_reg, state_next;
    logic [2:0]              post_reg, post_next;
    logic [LEN_W-1:0]        expected_reg, expected_next;
    logic [LEN_W-1:0]        rcount_reg, rcount_next;
    logic [SEQ_W-1:0]        seq_reg, seq_next;
    logic [TIMER_W-1:0]      gap_reg, gap_next;
    logic                    running_reg, running_next;
    logic [SID_W-1:0]        sid_reg, sid_next;
    logic                    dest_reg, dest_next;
    logic [LEN_W-1:0]        deliv_len_reg, deliv_len_next;
    logic [LEN_W-1:0]        rem_reg, rem_next;
    logic [STORE_ADDR_W-1:0] widx_reg, widx_next;
    logic [STORE_ADDR_W-1:0] w2_addr_reg, w2_addr_next;
    logic [BYTES_W-1:0]      w2_data_reg, w2_data_next;
    logic [7:0]              w2_be_reg, w2_be_next;
    result_t                 pend_reg, pend_next;

    // Output register
    logic    out_valid_reg;
    result_t out_reg;
    logic    out_load;
    result_t out_word;
    logic    slot_free;

    // Message store, one write port and one registered read port
    logic [BYTES_W-1:0]      store_mem [STORE_WORDS];
    logic                    mem_we;
    logic [STORE_ADDR_W-1:0] mem_waddr;
    logic [BYTES_W-1:0]      mem_wdata;
    logic [7:0]              mem_be;
    logic                    mem_rd;
    logic [BYTES_W-1:0]      mem_rdata_reg;

    // Decode helpers
    logic                    in_accept;
    logic [7:0]              f0, f1;
    logic [3:0]              ftype;
    logic [11:0]             ff_len;
    logic [LEN_W-1:0]        len_limit;
    logic [TIMER_W-1:0]      gap_inc;
    logic [2:0]              cf_off;
    logic [127:0]            cf_wide;
    logic [15:0]             cf_be;
    logic [STORE_ADDR_W-1:0] cf_addr;
    logic [LEN_W-1:0]        rcount_add;
    logic [1:0]              sf_route, cf_route;
    logic [3:0]              cnt_now;
    logic                    cfg_write;

    // Keep bytes 0..cnt-1, byte 0 in the top bits
    function automatic logic [BYTES_W-1:0] byte_mask(input logic [COUNT_W-1:0] cnt);
        logic [BYTES_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (COUNT_W'(i) < cnt) begin
                m[BYTES_W-1-8*i -: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // Route by service ID: bit 1 = routable, bit 0 = destination
    function automatic logic [1:0] route(input logic [SID_W-1:0] sid,
                                         input logic [SID_W-1:0] obd,
                                         input logic [SID_W-1:0] uds);
        logic [1:0] r;
        if (sid >= obd && sid < uds) begin
            r = 2'b10;
        end
        else if (sid >= uds) begin
            r = 2'b11;
        end
        else begin
            r = 2'b00;
        end
        return r;
    endfunction

    function automatic result_t flow_word(input logic [3:0] code,
                                          input logic [7:0] sep,
                                          input logic       last);
        result_t r;
        r.result_kind    = KIND_FLOW;
        r.result_bytes   = {FC_BASE, code, 8'h00, sep, 40'h0};
        r.byte_count     = COUNT_W'(3);
        r.destination    = 1'b0;
        r.message_length = '0;
        r.last_word      = last;
        return r;
    endfunction

    // Decode the incoming beat
    assign in_accept = frame.valid && frame.ready;
    assign f0        = frame.frame_bytes[63:56];
    assign f1        = frame.frame_bytes[55:48];
    assign ftype     = f0[7:4];
    assign ff_len    = {f0[3:0], f1};
    assign len_limit = (max_len_reg > LEN_W'(LIMIT_CAP)) ? LEN_W'(LIMIT_CAP) : max_len_reg;
    assign gap_inc   = (gap_reg != '1) ? gap_reg + TIMER_W'(1) : gap_reg;
    assign sf_route  = route(f1, obd_first_reg, uds_first_reg);
    assign cf_route  = route(sid_reg, obd_first_reg, uds_first_reg);

    // Place the seven consecutive-frame bytes across two store words
    assign cf_off     = rcount_reg[2:0];
    assign cf_wide    = {frame.frame_bytes[55:0], 72'h0} >> {cf_off, 3'b000};
    assign cf_be      = 16'hFE00 >> cf_off;
    assign cf_addr    = STORE_ADDR_W'(rcount_reg >> 3);
    assign rcount_add = rcount_reg + LEN_W'(7);
    assign cnt_now    = (rem_reg >= LEN_W'(8)) ? 4'd8 : rem_reg[3:0];

    assign slot_free   = !out_valid_reg || result.ready;
    assign frame.ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        post_next      = post_reg;
        expected_next  = expected_reg;
        rcount_next    = rcount_reg;
        seq_next       = seq_reg;
        gap_next       = gap_reg;
        running_next   = running_reg;
        sid_next       = sid_reg;
        dest_next      = dest_reg;
        deliv_len_next = deliv_len_reg;
        rem_next       = rem_reg;
        widx_next      = widx_reg;
        w2_addr_next   = w2_addr_reg;
        w2_data_next   = w2_data_reg;
        w2_be_next     = w2_be_reg;
        pend_next      = pend_reg;
        mem_we         = 1'b0;
        mem_waddr      = cf_addr;
        mem_wdata      = cf_wide[127:64];
        mem_be         = cf_be[15:8];
        mem_rd         = 1'b0;
        out_load       = 1'b0;
        out_word       = pend_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept) begin
                    if (frame.mode) begin
                        // Timer tick: advance gap timer, abort on expiry
                        if (running_reg) begin
                            gap_next = gap_inc;
                            if (gap_inc >= timeout_reg) begin
                                expected_next = '0;
                                rcount_next   = '0;
                                seq_next      = '0;
                                gap_next      = '0;
                                running_next  = 1'b0;
                                pend_next     = flow_word(FC_ABORT, sep_time_reg, 1'b1);
                                state_next    = S_PEND;
                            end
                        end
                    end
                    else if (ftype == TYPE_SINGLE) begin
                        if (f0[3:0] == 4'd0 || f0[3:0] > 4'd7 || !sf_route[1]) begin
                            pend_next = flow_word(FC_ABORT, sep_time_reg, 1'b1);
                        end
                        else begin
                            pend_next.result_kind    = KIND_DATA;
                            pend_next.result_bytes   = {frame.frame_bytes[55:0], 8'h00} &
                                                       byte_mask(f0[3:0]);
                            pend_next.byte_count     = f0[3:0];
                            pend_next.destination    = sf_route[0];
                            pend_next.message_length = LEN_W'(f0[3:0]);
                            pend_next.last_word      = 1'b1;
                        end
                        state_next = S_PEND;
                    end
                    else if (ftype == TYPE_FIRST) begin
                        if (ff_len < 12'd8 || ff_len > {3'b000, len_limit}) begin
                            expected_next = '0;
                            rcount_next   = '0;
                            seq_next      = '0;
                            gap_next      = '0;
                            running_next  = 1'b0;
                            pend_next     = flow_word(FC_ABORT, sep_time_reg, 1'b1);
                        end
                        else begin
                            // Store the six leading bytes in word 0
                            mem_we        = 1'b1;
                            mem_waddr     = '0;
                            mem_wdata     = {frame.frame_bytes[47:0], 16'h0};
                            mem_be        = 8'hFC;
                            expected_next = ff_len[LEN_W-1:0];
                            rcount_next   = LEN_W'(6);
                            seq_next      = '0;
                            gap_next      = '0;
                            running_next  = 1'b1;
                            sid_next      = frame.frame_bytes[47:40];
                            pend_next     = flow_word(FC_CONT, sep_time_reg, 1'b1);
                        end
                        state_next = (expected_reg != '0) ? S_WAIT : S_PEND;
                    end
                    else if (ftype == TYPE_CONSEC) begin
                        if (expected_reg == '0) begin
                            pend_next  = flow_word(FC_ABORT, sep_time_reg, 1'b1);
                            state_next = S_PEND;
                        end
                        else if (f0[3:0] != seq_reg + SEQ_W'(1)) begin
                            expected_next = '0;
                            rcount_next   = '0;
                            seq_next      = '0;
                            gap_next      = '0;
                            running_next  = 1'b0;
                            pend_next     = flow_word(FC_ABORT, sep_time_reg, 1'b1);
                            state_next    = S_PEND;
                        end
                        else begin
                            // Write the head now, hold the tail for the next cycle
                            mem_we       = 1'b1;
                            w2_addr_next = cf_addr + STORE_ADDR_W'(1);
                            w2_data_next = cf_wide[63:0];
                            w2_be_next   = cf_be[7:0];
                            rcount_next  = rcount_add;
                            seq_next     = seq_reg + SEQ_W'(1);
                            state_next   = S_CF2;
                            if (rcount_add >= expected_reg) begin
                                expected_next  = '0;
                                rcount_next    = '0;
                                seq_next       = '0;
                                gap_next       = '0;
                                running_next   = 1'b0;
                                deliv_len_next = expected_reg;
                                rem_next       = expected_reg;
                                widx_next      = '0;
                                dest_next      = cf_route[0];
                                if (cf_route[1]) begin
                                    post_next = S_RD;
                                end
                                else begin
                                    pend_next = flow_word(FC_ABORT, sep_time_reg, 1'b1);
                                    post_next = S_PEND;
                                end
                            end
                            else begin
                                gap_next  = '0;
                                post_next = S_IDLE;
                            end
                        end
                    end
                    else if (ftype != TYPE_FLOW) begin
                        pend_next  = flow_word(FC_ABORT, sep_time_reg, 1'b1);
                        state_next = S_PEND;
                    end
                end
            end
            S_WAIT:
            begin
                // First frame while busy: wait reply ahead of the verdict
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_word   = flow_word(FC_WAIT, sep_time_reg, 1'b0);
                    state_next = S_PEND;
                end
            end
            S_PEND:
            begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_word   = pend_reg;
                    state_next = S_IDLE;
                end
            end
            S_CF2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = w2_addr_reg;
                mem_wdata  = w2_data_reg;
                mem_be     = w2_be_reg;
                state_next = post_reg;
            end
            S_RD:
            begin
                mem_rd     = 1'b1;
                state_next = S_DW;
            end
            S_DW:
            begin
                // Emit one stored word, trimmed to the bytes that remain
                if (slot_free) begin
                    out_load                = 1'b1;
                    out_word.result_kind    = KIND_DATA;
                    out_word.result_bytes   = mem_rdata_reg & byte_mask(cnt_now);
                    out_word.byte_count     = cnt_now;
                    out_word.destination    = dest_reg;
                    out_word.message_length = deliv_len_reg;
                    out_word.last_word      = (rem_reg <= LEN_W'(8));
                    if (rem_reg <= LEN_W'(8)) begin
                        state_next = S_IDLE;
                    end
                    else begin
                        rem_next   = rem_reg - LEN_W'(8);
                        widx_next  = widx_reg + STORE_ADDR_W'(1);
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            post_reg      <= S_IDLE;
            expected_reg  <= '0;
            rcount_reg    <= '0;
            seq_reg       <= '0;
            gap_reg       <= '0;
            running_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg    <= state_next;
            post_reg     <= post_next;
            expected_reg <= expected_next;
            rcount_reg   <= rcount_next;
            seq_reg      <= seq_next;
            gap_reg      <= gap_next;
            running_reg  <= running_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sid_reg       <= sid_next;
        dest_reg      <= dest_next;
        deliv_len_reg <= deliv_len_next;
        rem_reg       <= rem_next;
        widx_reg      <= widx_next;
        w2_addr_reg   <= w2_addr_next;
        w2_data_reg   <= w2_data_next;
        w2_be_reg     <= w2_be_next;
        pend_reg      <= pend_next;
        if (out_load) begin
            out_reg <= out_word;
        end
    end

    // Message store: byte-enabled write, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            for (int i = 0; i < 8; i++) begin
                if (mem_be[i]) begin
                    store_mem[mem_waddr][8*i +: 8] <= mem_wdata[8*i +: 8];
                end
            end
        end
        if (mem_rd) begin
            mem_rdata_reg <= store_mem[widx_reg];
        end
    end

    // Drive the result channel
    assign result.valid          = out_valid_reg;
    assign result.result_kind    = out_reg.result_kind;
    assign result.result_bytes   = out_reg.result_bytes;
    assign result.byte_count     = out_reg.byte_count;
    assign result.destination    = out_reg.destination;
    assign result.message_length = out_reg.message_length;
    assign result.last_word      = out_reg.last_word;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_len_reg   <= LEN_W'(256);
            obd_first_reg <= SID_W'(1);
            uds_first_reg <= SID_W'(16);
            timeout_reg   <= TIMER_W'(200);
            sep_time_reg  <= 8'd10;
        end
        else if (cfg_write) begin
            unique case (paddr[4:2])
                REG_MAX_LEN:   max_len_reg   <= pwdata[LEN_W-1:0];
                REG_OBD_FIRST: obd_first_reg <= pwdata[SID_W-1:0];
                REG_UDS_FIRST: uds_first_reg <= pwdata[SID_W-1:0];
                REG_TIMEOUT:   timeout_reg   <= pwdata[TIMER_W-1:0];
                REG_SEP_TIME:  sep_time_reg  <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_MAX_LEN:   prdata = CFG_DATA_W'(max_len_reg);
            REG_OBD_FIRST: prdata = CFG_DATA_W'(obd_first_reg);
            REG_UDS_FIRST: prdata = CFG_DATA_W'(uds_first_reg);
            REG_TIMEOUT:   prdata = CFG_DATA_W'(timeout_reg);
            REG_SEP_TIME:  prdata = CFG_DATA_W'(sep_time_reg);
            default:       prdata = '0;
        endcase
    end

    // Idle reassembly never leaves the gap timer running
    assert property (@(posedge clk) disable iff (!rst_n)
        (expected_reg == '0) |-> !running_reg)
        else $error("gap timer running with no reassembly in progress");

    // An open reassembly always has bytes still to come
    assert property (@(posedge clk) disable iff (!rst_n)
        (expected_reg != '0) |-> (rcount_reg < expected_reg))
        else $error("reassembly left open after its last byte");

    // No store write while delivery reads the store
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD || state_reg == S_DW) |-> !mem_we)
        else $error("store written during delivery");

    // A taken result that is not last is followed by more work, not idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !out_word.last_word) |=> (state_reg != S_IDLE))
        else $error("run ended without a last result");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the ISO-TP receive reassembler with a built-in frame predictor.
module tb_top import isotp_rr_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic       DEST_OBD          = 1'b0;
    localparam logic       DEST_UDS          = 1'b1;
    localparam logic [3:0] TYPE_RESERVED_MIN = 4'h4;
    localparam logic [3:0] TYPE_RESERVED_MAX = 4'hF;
    localparam int         SETTLE_CYCLES     = 80;
    localparam int         MAX_REPORTS       = 10;

    // Predicts reply and data beats per frame and checks them in order
    class reassembly_checker;
        logic [LEN_W-1:0]   max_len;
        logic [SID_W-1:0]   obd_first;
        logic [SID_W-1:0]   uds_first;
        logic [TIMER_W-1:0] timeout;
        logic [7:0]         sep_time;
        logic [7:0]         message_bytes [BUFFER_BYTES+8];
        int                 want_len;
        int                 got_count;
        logic [SEQ_W-1:0]   seq;
        logic [TIMER_W-1:0] gap;
        bit                 running;
        result_t            awaited [$];
        int                 failures;

        function new();
            max_len   = 9'd256;
            obd_first = 8'd1;
            uds_first = 8'd16;
            timeout   = 16'd200;
            sep_time  = 8'd10;
            failures  = 0;
            abandon_message();
        endfunction

        function void abandon_message();
            want_len  = 0;
            got_count = 0;
            seq       = '0;
            gap       = '0;
            running   = 1'b0;
        endfunction

        function int length_cap();
            return (int'(max_len) > LIMIT_CAP) ? LIMIT_CAP : int'(max_len);
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void set_register(logic [2:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_MAX_LEN:   max_len   = value[LEN_W-1:0];
                REG_OBD_FIRST: obd_first = value[SID_W-1:0];
                REG_UDS_FIRST: uds_first = value[SID_W-1:0];
                REG_TIMEOUT:   timeout   = value[TIMER_W-1:0];
                REG_SEP_TIME:  sep_time  = value[7:0];
                default: ;
            endcase
        endfunction

        function void add_flow(logic [3:0] code);
            result_t r;
            r.result_kind    = KIND_FLOW;
            r.result_bytes   = {FC_BASE, code, 8'h00, sep_time, 40'h0};
            r.byte_count     = 4'd3;
            r.destination    = DEST_OBD;
            r.message_length = '0;
            r.last_word      = 1'b0;
            awaited.push_back(r);
        endfunction

        // Route by service ID, then split into eight-byte words
        function void route_message(logic [7:0] data [BUFFER_BYTES+8], int len);
            result_t r;
            logic    dest;
            int      pos, cnt, k;
            if (data[0] >= obd_first && data[0] < uds_first)
                dest = DEST_OBD;
            else if (data[0] >= uds_first)
                dest = DEST_UDS;
            else begin
                add_flow(FC_ABORT);
                return;
            end
            for (pos = 0; pos < len; pos += 8) begin
                cnt = (len - pos > 8) ? 8 : len - pos;
                r.result_bytes = '0;
                for (k = 0; k < cnt; k++)
                    r.result_bytes[63-8*k -: 8] = data[pos+k];
                r.result_kind    = KIND_DATA;
                r.byte_count     = 4'(cnt);
                r.destination    = dest;
                r.message_length = 9'(len);
                r.last_word      = 1'b0;
                awaited.push_back(r);
            end
        endfunction

        function void take_frame(logic tick, logic [BYTES_W-1:0] bytes);
            logic [7:0]       f [8];
            logic [7:0]       single [BUFFER_BYTES+8];
            logic [SEQ_W-1:0] next_seq;
            int               base, len, i;
            base = awaited.size();
            for (i = 0; i < 8; i++)
                f[i] = bytes[63-8*i -: 8];
            if (tick) begin
                // Advance the gap timer; drop the message on expiry
                if (running) begin
                    if (gap != '1)
                        gap++;
                    if (gap >= timeout) begin
                        abandon_message();
                        add_flow(FC_ABORT);
                    end
                end
            end else begin
                case (f[0][7:4])
                    TYPE_SINGLE: begin
                        len = f[0][3:0];
                        if (len == 0 || len > 7)
                            add_flow(FC_ABORT);
                        else begin
                            for (i = 0; i < 7; i++)
                                single[i] = f[i+1];
                            route_message(single, len);
                        end
                    end
                    TYPE_FIRST: begin
                        if (want_len != 0)
                            add_flow(FC_WAIT);
                        len = {f[0][3:0], f[1]};
                        if (len < 8 || len > length_cap()) begin
                            abandon_message();
                            add_flow(FC_ABORT);
                        end else begin
                            for (i = 0; i < 6; i++)
                                message_bytes[i] = f[i+2];
                            want_len  = len;
                            got_count = 6;
                            seq       = '0;
                            gap       = '0;
                            running   = 1'b1;
                            add_flow(FC_CONT);
                        end
                    end
                    TYPE_CONSEC: begin
                        next_seq = seq + 4'd1;
                        if (want_len == 0)
                            add_flow(FC_ABORT);
                        else if (f[0][3:0] != next_seq) begin
                            abandon_message();
                            add_flow(FC_ABORT);
                        end else begin
                            for (i = 0; i < 7; i++)
                                message_bytes[got_count+i] = f[i+1];
                            got_count += 7;
                            seq = next_seq;
                            if (got_count >= want_len) begin
                                len = want_len;
                                abandon_message();
                                route_message(message_bytes, len);
                            end else
                                gap = '0;
                        end
                    end
                    TYPE_FLOW: ;
                    default: add_flow(FC_ABORT);
                endcase
            end
            if (awaited.size() > base)
                awaited[awaited.size()-1].last_word = 1'b1;
        endfunction

        function void match_result(result_t got);
            result_t want;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("ERROR unexpected beat: kind=%0d bytes=%h count=%0d dest=%0d len=%0d last=%0d",
                             got.result_kind, got.result_bytes, got.byte_count,
                             got.destination, got.message_length, got.last_word);
                return;
            end
            want = awaited.pop_front();
            if (got.result_kind !== want.result_kind || got.result_bytes !== want.result_bytes ||
                got.byte_count !== want.byte_count || got.destination !== want.destination ||
                got.message_length !== want.message_length || got.last_word !== want.last_word) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("ERROR beat mismatch at %0t", $realtime);
                    $display("  expected kind=%0d bytes=%h count=%0d dest=%0d len=%0d last=%0d",
                             want.result_kind, want.result_bytes, want.byte_count,
                             want.destination, want.message_length, want.last_word);
                    $display("  actual   kind=%0d bytes=%h count=%0d dest=%0d len=%0d last=%0d",
                             got.result_kind, got.result_bytes, got.byte_count,
                             got.destination, got.message_length, got.last_word);
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    result_t               seen_beat;
    reassembly_checker     sb;
    int                    tx_idle_pct;
    int                    rx_idle_pct;
    int                    counted_frames;

    isotp_rr_frame_if  frame_ch ();
    isotp_rr_result_if result_ch ();

    isotp_receive_reassembler_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame   (frame_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    // Stall the result channel at random
    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

    assign seen_beat = {result_ch.result_kind, result_ch.result_bytes, result_ch.byte_count,
                        result_ch.destination, result_ch.message_length, result_ch.last_word};

    // Check every accepted result beat
    always @(posedge clk)
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.match_result(seen_beat);

    function automatic logic [BYTES_W-1:0] frame_word(logic [3:0] kind, logic [3:0] low,
                                                     logic [55:0] rest);
        return {kind, low, rest};
    endfunction

    // Offer one beat on the frame channel, with random idle cycles ahead of it
    task automatic push_frame(logic tick, logic [BYTES_W-1:0] bytes);
        while ($urandom_range(99) < tx_idle_pct) begin
            frame_ch.valid <= 1'b0;
            @(posedge clk);
        end
        frame_ch.valid       <= 1'b1;
        frame_ch.mode        <= tick;
        frame_ch.frame_bytes <= bytes;
        do @(posedge clk); while (!frame_ch.ready);
        sb.take_frame(tick, bytes);
        if (!tick && bytes[63:60] != TYPE_FLOW)
            counted_frames++;
    endtask

    // Hold the sender until every expected beat is out, then let the block settle
    task automatic quiesce();
        frame_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // First frame, then consecutive frames with occasional ticks and faults
    task automatic send_message(int len);
        logic [BYTES_W-1:0] bytes;
        logic [SEQ_W-1:0]   sq;
        int                 n_cf, k;
        bytes = {$urandom, $urandom};
        bytes[63:48] = {TYPE_FIRST, 12'(len)};
        push_frame(1'b0, bytes);
        n_cf = (len - 6 + 6) / 7;
        if (len < 8 || len > sb.length_cap())
            n_cf = $urandom_range(0, 2);
        for (k = 1; k <= n_cf; k++) begin
            if ($urandom_range(99) < 6)
                push_frame(1'b1, {$urandom, $urandom});
            if ($urandom_range(99) < 2)
                break;
            sq = k[3:0];
            if ($urandom_range(99) < 3)
                sq = sq + 4'($urandom_range(1, 15));
            bytes = {$urandom, $urandom};
            bytes[63:56] = {TYPE_CONSEC, sq};
            push_frame(1'b0, bytes);
        end
    endtask

    task automatic run_directed();
        push_frame(1'b1, '1);
        push_frame(1'b0, frame_word(TYPE_SINGLE, 4'd0, '0));
        push_frame(1'b0, frame_word(TYPE_SINGLE, 4'd8, 56'h11_2233_4455_6677));
        push_frame(1'b0, frame_word(TYPE_SINGLE, 4'd15, '1));
        push_frame(1'b0, frame_word(TYPE_SINGLE, 4'd7, 56'h22_FFFF_FFFF_FFFF));
        push_frame(1'b0, frame_word(TYPE_SINGLE, 4'd3, 56'h09_AA55_C3C3_C3C3));
        // service ID below both ranges
        push_frame(1'b0, frame_word(TYPE_SINGLE, 4'd1, 56'h00_0000_0000_0000));
        // boundary between the OBD and UDS ranges
        push_frame(1'b0, frame_word(TYPE_SINGLE, 4'd2, 56'h0F_0100_0000_0000));
        push_frame(1'b0, frame_word(TYPE_SINGLE, 4'd2, 56'h10_0200_0000_0000));
        // first frame too short, then too long
        push_frame(1'b0, frame_word(TYPE_FIRST, 4'd0, 56'h07_3E00_0000_0000));
        push_frame(1'b0, frame_word(TYPE_FIRST, 4'hF, 56'hFF_3E00_0000_0000));
        push_frame(1'b0, frame_word(TYPE_CONSEC, 4'd1, '1));
        push_frame(1'b0, frame_word(TYPE_FLOW, FC_CONT, 56'h00_0A00_0000_0000));
        push_frame(1'b0, frame_word(TYPE_RESERVED_MIN, 4'd0, '0));
        push_frame(1'b0, frame_word(TYPE_RESERVED_MAX, 4'hF, '1));
        // shortest segmented message
        push_frame(1'b0, frame_word(TYPE_FIRST, 4'd0, 56'h08_2201_0203_0405));
        push_frame(1'b0, frame_word(TYPE_CONSEC, 4'd1, 56'h06_0700_0000_0000));
        // sequence error
        push_frame(1'b0, frame_word(TYPE_FIRST, 4'd0, 56'h14_1011_1213_1415));
        push_frame(1'b0, frame_word(TYPE_CONSEC, 4'd3, '1));
        // restart while busy
        push_frame(1'b0, frame_word(TYPE_FIRST, 4'd0, 56'h14_2021_2223_2425));
        push_frame(1'b0, frame_word(TYPE_FIRST, 4'd0, 56'h09_0531_3233_3435));
        push_frame(1'b0, frame_word(TYPE_CONSEC, 4'd1, 56'h36_3738_393A_3B3C));
        // gap timer expiry
        push_frame(1'b0, frame_word(TYPE_FIRST, 4'd0, 56'h14_2241_4243_4445));
        push_frame(1'b1, '0);
        push_frame(1'b1, {$urandom, $urandom});
    endtask

    task automatic run_phase(int max_len, int obd, int uds, int tmo, int sep,
                             int tx_pct, int rx_pct, int budget);
        logic [BYTES_W-1:0] bytes;
        int                 stop, hold_at, len, pick, hi;
        bit                 held;
        quiesce();
        write_register(REG_MAX_LEN, max_len);
        write_register(REG_OBD_FIRST, obd);
        write_register(REG_UDS_FIRST, uds);
        write_register(REG_TIMEOUT, tmo);
        write_register(REG_SEP_TIME, sep);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop    = counted_frames + budget;
        hold_at = counted_frames + $urandom_range(3, budget - 3);
        held    = 1'b0;
        send_message(sb.length_cap());
        while (counted_frames < stop) begin
            if (!held && counted_frames >= hold_at) begin
                quiesce();
                held = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 55) begin
                // mostly short messages, a few at the limit or out of range
                hi   = (sb.length_cap() < 8) ? 8 : sb.length_cap();
                pick = $urandom_range(99);
                if (pick < 75)
                    len = $urandom_range(8, (hi < 40) ? hi : 40);
                else if (pick < 90)
                    len = $urandom_range(8, hi);
                else if (pick < 95)
                    len = hi;
                else
                    len = $urandom_range(0, 4095);
                send_message(len);
            end else if (pick < 75) begin
                bytes = {$urandom, $urandom};
                if ($urandom_range(9) != 0)
                    bytes[63:56] = {TYPE_SINGLE, 4'($urandom_range(1, 7))};
                else
                    bytes[63:60] = TYPE_SINGLE;
                push_frame(1'b0, bytes);
            end else if (pick < 85)
                push_frame(1'b1, {$urandom, $urandom});
            else
                push_frame(1'b0, {$urandom, $urandom});
        end
    endtask

    initial begin
        sb                   = new();
        rst_n                = 1'b0;
        frame_ch.valid       = 1'b0;
        frame_ch.mode        = 1'b0;
        frame_ch.frame_bytes = '0;
        result_ch.ready      = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        counted_frames       = 0;
        tx_idle_pct          = 24;
        rx_idle_pct          = 82;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // shorten the gap timer so the directed frames reach expiry
        write_register(REG_TIMEOUT, 2);
        run_directed();

        run_phase(256, 0, 255, 1, 255, 24, 82, 40);
        run_phase(40, 32, 16, 20, 0, 24, 82, 40);
        run_phase(7, 255, 0, 65535, 8'h5A, 82, 24, 40);
        run_phase(100, 1, 16, 3, 0, 82, 24, 40);
        run_phase(256, 16, 128, 200, 8'hA5, 0, 0, 40);

        quiesce();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog for a hung handshake
    initial begin
        #1_500_000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
